FILE: src/bra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bra_pkg
// Shared types, constants and helpers of the buddy range allocator.
// ----------------------------------------------------------------------------
package bra_pkg;

  localparam int TOTAL_PAGES = 2048;
  localparam int PAGE_W      = 11;
  localparam int COUNT_W     = 12;
  localparam int LG_W        = 4;
  localparam int TOP_LG      = 11;
  localparam int MAX_RANGES  = 64;
  localparam int IDX_W       = 6;
  localparam int CNT_W       = 7;

  typedef enum logic [1:0] {
    MODE_BEST = 2'd0,
    MODE_AT   = 2'd1,
    MODE_FREE = 2'd2,
    MODE_BAD  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_SPACE  = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_MISMATCH  = 3'd3,
    ST_FULL      = 3'd4,
    ST_MISALIGN  = 3'd5
  } status_t;

  typedef struct packed {
    logic [PAGE_W-1:0] start;
    logic [LG_W-1:0]   lg;
    logic              alloc;
  } entry_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_INIT, OP_LOAD, OP_SCAN, OP_SHU_INIT, OP_SHU_RD, OP_SHU_WR,
    OP_SPLIT_LO, OP_SPLIT_HI, OP_GRANT, OP_FREE, OP_MRG_RD, OP_MRG_EV,
    OP_MRG_WR, OP_RM_RD, OP_RM_WR, OP_RM_END, OP_ERR, OP_EMIT
  } dp_op_t;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_SCAN, S_DECIDE, S_SPLIT_CHK, S_SHU_CHK, S_SHU_RD,
    S_SHU_WR, S_SPLIT_LO, S_SPLIT_HI, S_GRANT, S_FREE, S_MRG_CHK, S_MRG_EV,
    S_MRG_WR, S_RM_CHK, S_RM_RD, S_RM_WR, S_RM_END, S_ERR, S_EMIT
  } state_t;

  typedef struct packed {
    logic             scan_done;
    logic             err;
    mode_t            mode;
    logic             split_more;
    logic             shu_done;
    logic             has_partner;
    logic             mrg_match;
    logic             rm_done;
    logic [CNT_W-1:0] count;
  } dp_stat_t;

  // smallest k with 2^k >= n, zero count treated as one
  function automatic logic [LG_W-1:0] ceil_lg(input logic [COUNT_W-1:0] n);
    logic [LG_W-1:0] r;
    r = '0;
    for (int k = COUNT_W; k >= 0; k--) begin
      if ({1'b0, n} <= ((COUNT_W+1)'(1) << k)) r = LG_W'(k);
    end
    return r;
  endfunction

endpackage

FILE: src/bra_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bra_req_if / bra_rsp_if
// Valid/ready channels for allocator requests and responses.
// ----------------------------------------------------------------------------
interface bra_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [11:0] page_count;
  logic [10:0] page_offset;
  modport source (output valid, mode, page_count, page_offset, input ready);
  modport sink (input valid, mode, page_count, page_offset, output ready);
endinterface

interface bra_rsp_if;
  logic        valid;
  logic        ready;
  logic [10:0] block_offset;
  logic [11:0] block_pages;
  logic [2:0]  status;
  modport source (output valid, block_offset, block_pages, status, input ready);
  modport sink (input valid, block_offset, block_pages, status, output ready);
endinterface

FILE: src/bra_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bra_dp
// Range table memory, scan/split/merge registers and response registers.
// ----------------------------------------------------------------------------
module bra_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  bra_pkg::dp_op_t               op,
  output bra_pkg::dp_stat_t             stat,
  input  logic [1:0]                    in_mode,
  input  logic [bra_pkg::COUNT_W-1:0]   in_count,
  input  logic [bra_pkg::PAGE_W-1:0]    in_offset,
  output logic [bra_pkg::PAGE_W-1:0]    block_offset,
  output logic [bra_pkg::COUNT_W-1:0]   block_pages,
  output logic [2:0]                    status
);

  bra_pkg::entry_t mem [bra_pkg::MAX_RANGES];
  bra_pkg::entry_t rdata;

  logic [bra_pkg::CNT_W-1:0]   count;
  bra_pkg::mode_t              mode;
  logic [bra_pkg::COUNT_W-1:0] cnt_eff;
  logic [bra_pkg::PAGE_W-1:0]  off;
  logic [bra_pkg::LG_W-1:0]    req_lg;
  logic [bra_pkg::CNT_W-1:0]   scan_idx;
  logic                        scan_pend;
  logic [bra_pkg::IDX_W-1:0]   ev_idx;
  logic                        found;
  logic [bra_pkg::IDX_W-1:0]   sel;
  logic [bra_pkg::PAGE_W-1:0]  cur_start;
  logic [bra_pkg::LG_W-1:0]    cur_lg;
  logic                        cur_alloc;
  logic [bra_pkg::CNT_W-1:0]   j;
  logic [bra_pkg::PAGE_W-1:0]  res_off;
  logic [bra_pkg::COUNT_W-1:0] res_pages;
  bra_pkg::status_t            res_status;

  logic [bra_pkg::PAGE_W:0]    half;
  logic [bra_pkg::PAGE_W-1:0]  upper_start;
  logic [bra_pkg::PAGE_W:0]    start_sh;
  logic                        lower;
  logic [bra_pkg::CNT_W-1:0]   sel_p1;
  logic [bra_pkg::IDX_W-1:0]   partner;
  logic [bra_pkg::LG_W-1:0]    n_split;
  logic                        full;
  logic [bra_pkg::COUNT_W-1:0] mask;
  logic                        misalign;
  logic                        pow2;
  bra_pkg::status_t            code;
  logic [bra_pkg::PAGE_W:0]    ent_end;
  logic                        hit;
  logic [bra_pkg::COUNT_W-1:0] req_pages;
  logic [bra_pkg::COUNT_W-1:0] in_eff;

  logic [bra_pkg::IDX_W-1:0]   rd_addr;
  logic                        wr_en;
  logic [bra_pkg::IDX_W-1:0]   wr_addr;
  bra_pkg::entry_t             wr_data;

  always_comb begin
    half        = (bra_pkg::PAGE_W+1)'(1) << (cur_lg - bra_pkg::LG_W'(1));
    upper_start = cur_start + half[bra_pkg::PAGE_W-1:0];
    start_sh    = {1'b0, cur_start} >> cur_lg;
    lower       = ~start_sh[0];
    sel_p1      = {1'b0, sel} + bra_pkg::CNT_W'(1);
    partner     = lower ? (sel + bra_pkg::IDX_W'(1)) : (sel - bra_pkg::IDX_W'(1));
    n_split     = cur_lg - req_lg;
    full        = ({1'b0, count} + (bra_pkg::CNT_W+1)'(n_split))
                  > (bra_pkg::CNT_W+1)'(bra_pkg::MAX_RANGES);
    mask        = bra_pkg::COUNT_W'(((bra_pkg::COUNT_W+1)'(1) << req_lg) - 1'b1);
    misalign    = ({1'b0, off} & mask) != '0;
    pow2        = (cnt_eff & (cnt_eff - bra_pkg::COUNT_W'(1))) == '0;
    req_pages   = bra_pkg::COUNT_W'((bra_pkg::COUNT_W+1)'(1) << req_lg);
    in_eff      = (in_count == '0) ? bra_pkg::COUNT_W'(1) : in_count;
    ent_end     = {1'b0, rdata.start} + ((bra_pkg::PAGE_W+1)'(1) << rdata.lg);
  end

  // request check after the scan
  always_comb begin
    code = bra_pkg::ST_OK;
    case (mode)
      bra_pkg::MODE_BEST: begin
        if (!found) code = bra_pkg::ST_NO_SPACE;
        else if (full) code = bra_pkg::ST_FULL;
      end
      bra_pkg::MODE_AT: begin
        if (!pow2) code = bra_pkg::ST_MISMATCH;
        else if (misalign) code = bra_pkg::ST_MISALIGN;
        else if (!found) code = bra_pkg::ST_NOT_FOUND;
        else if (cur_alloc || cur_lg < req_lg) code = bra_pkg::ST_MISMATCH;
        else if (full) code = bra_pkg::ST_FULL;
      end
      bra_pkg::MODE_FREE: begin
        if (!found) code = bra_pkg::ST_NOT_FOUND;
        else if (!cur_alloc || cur_lg != req_lg) code = bra_pkg::ST_MISMATCH;
      end
      default: code = bra_pkg::ST_NOT_FOUND;
    endcase
  end

  // scan match on the entry just read
  always_comb begin
    case (mode)
      bra_pkg::MODE_BEST:
        hit = !rdata.alloc && rdata.lg >= req_lg && (!found || rdata.lg < cur_lg);
      bra_pkg::MODE_AT:
        hit = !found && rdata.start <= off && {1'b0, off} < ent_end;
      bra_pkg::MODE_FREE:
        hit = !found && rdata.start == off;
      default:
        hit = 1'b0;
    endcase
  end

  always_comb begin
    stat.scan_done   = (scan_idx == count) && !scan_pend;
    stat.err         = code != bra_pkg::ST_OK;
    stat.mode        = mode;
    stat.split_more  = cur_lg > req_lg;
    stat.shu_done    = j <= sel_p1;
    stat.has_partner = lower ? (sel_p1 < count) : (sel != '0);
    stat.mrg_match   = !rdata.alloc && rdata.lg == cur_lg;
    stat.rm_done     = ({1'b0, j} + (bra_pkg::CNT_W+1)'(1)) >= {1'b0, count};
    stat.count       = count;
  end

  // memory port control
  always_comb begin
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = rdata;
    case (op)
      bra_pkg::OP_SCAN:   rd_addr = scan_idx[bra_pkg::IDX_W-1:0];
      bra_pkg::OP_SHU_RD: rd_addr = j[bra_pkg::IDX_W-1:0] - bra_pkg::IDX_W'(1);
      bra_pkg::OP_RM_RD:  rd_addr = j[bra_pkg::IDX_W-1:0] + bra_pkg::IDX_W'(1);
      bra_pkg::OP_MRG_RD: rd_addr = partner;
      bra_pkg::OP_INIT: begin
        wr_en   = 1'b1;
        wr_data = '{start: '0, lg: bra_pkg::LG_W'(bra_pkg::TOP_LG), alloc: 1'b0};
      end
      bra_pkg::OP_SHU_WR, bra_pkg::OP_RM_WR: begin
        wr_en   = 1'b1;
        wr_addr = j[bra_pkg::IDX_W-1:0];
      end
      bra_pkg::OP_SPLIT_LO: begin
        wr_en   = 1'b1;
        wr_addr = sel;
        wr_data = '{start: cur_start, lg: cur_lg - bra_pkg::LG_W'(1), alloc: 1'b0};
      end
      bra_pkg::OP_SPLIT_HI: begin
        wr_en   = 1'b1;
        wr_addr = sel + bra_pkg::IDX_W'(1);
        wr_data = '{start: upper_start, lg: cur_lg - bra_pkg::LG_W'(1), alloc: 1'b0};
      end
      bra_pkg::OP_GRANT: begin
        wr_en   = 1'b1;
        wr_addr = sel;
        wr_data = '{start: cur_start, lg: cur_lg, alloc: 1'b1};
      end
      bra_pkg::OP_FREE, bra_pkg::OP_MRG_WR: begin
        wr_en   = 1'b1;
        wr_addr = sel;
        wr_data = '{start: cur_start, lg: cur_lg, alloc: 1'b0};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= bra_pkg::CNT_W'(1);
      scan_idx  <= '0;
      scan_pend <= 1'b0;
      found     <= 1'b0;
    end else begin
      case (op)
        bra_pkg::OP_INIT: count <= bra_pkg::CNT_W'(1);
        bra_pkg::OP_LOAD: begin
          mode      <= bra_pkg::mode_t'(in_mode);
          cnt_eff   <= in_eff;
          off       <= in_offset;
          req_lg    <= bra_pkg::ceil_lg(in_count);
          scan_idx  <= '0;
          scan_pend <= 1'b0;
          found     <= 1'b0;
        end
        bra_pkg::OP_SCAN: begin
          if (scan_idx < count) begin
            scan_idx  <= scan_idx + bra_pkg::CNT_W'(1);
            ev_idx    <= scan_idx[bra_pkg::IDX_W-1:0];
            scan_pend <= 1'b1;
          end else begin
            scan_pend <= 1'b0;
          end
          if (scan_pend && hit) begin
            found     <= 1'b1;
            sel       <= ev_idx;
            cur_start <= rdata.start;
            cur_lg    <= rdata.lg;
            cur_alloc <= rdata.alloc;
          end
        end
        bra_pkg::OP_SHU_INIT: j <= count;
        bra_pkg::OP_SHU_WR:   j <= j - bra_pkg::CNT_W'(1);
        bra_pkg::OP_SPLIT_HI: begin
          count  <= count + bra_pkg::CNT_W'(1);
          cur_lg <= cur_lg - bra_pkg::LG_W'(1);
          // allocate-at follows the half that holds the offset
          if (mode == bra_pkg::MODE_AT && off >= upper_start) begin
            sel       <= sel + bra_pkg::IDX_W'(1);
            cur_start <= upper_start;
          end
        end
        bra_pkg::OP_GRANT: begin
          res_off    <= cur_start;
          res_pages  <= req_pages;
          res_status <= bra_pkg::ST_OK;
        end
        bra_pkg::OP_FREE: begin
          res_off    <= off;
          res_pages  <= req_pages;
          res_status <= bra_pkg::ST_OK;
        end
        bra_pkg::OP_MRG_EV: begin
          if (stat.mrg_match) begin
            if (!lower) begin
              sel       <= partner;
              cur_start <= rdata.start;
            end
            cur_lg <= cur_lg + bra_pkg::LG_W'(1);
          end
        end
        bra_pkg::OP_MRG_WR: j <= sel_p1;
        bra_pkg::OP_RM_WR:  j <= j + bra_pkg::CNT_W'(1);
        bra_pkg::OP_RM_END: count <= count - bra_pkg::CNT_W'(1);
        bra_pkg::OP_ERR: begin
          res_off    <= '0;
          res_pages  <= '0;
          res_status <= code;
        end
        bra_pkg::OP_EMIT: begin
          block_offset <= res_off;
          block_pages  <= res_pages;
          status       <= res_status;
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: src/bra_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bra_ctrl
// Sequencer for scan, split, merge and response handshakes.
// ----------------------------------------------------------------------------
module bra_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  bra_pkg::dp_stat_t  stat,
  output bra_pkg::dp_op_t    op
);

  bra_pkg::state_t state, state_next;
  logic            can_emit;

  assign can_emit = !out_valid || out_ready;
  assign in_ready = state == bra_pkg::S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bra_pkg::S_INIT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (op == bra_pkg::OP_EMIT) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      bra_pkg::S_INIT: state_next = bra_pkg::S_IDLE;
      bra_pkg::S_IDLE: if (in_valid) state_next = bra_pkg::S_SCAN;
      bra_pkg::S_SCAN: if (stat.scan_done) state_next = bra_pkg::S_DECIDE;
      bra_pkg::S_DECIDE: begin
        if (stat.err) state_next = bra_pkg::S_ERR;
        else if (stat.mode == bra_pkg::MODE_FREE) state_next = bra_pkg::S_FREE;
        else state_next = bra_pkg::S_SPLIT_CHK;
      end
      bra_pkg::S_SPLIT_CHK:
        state_next = stat.split_more ? bra_pkg::S_SHU_CHK : bra_pkg::S_GRANT;
      bra_pkg::S_SHU_CHK:
        state_next = stat.shu_done ? bra_pkg::S_SPLIT_LO : bra_pkg::S_SHU_RD;
      bra_pkg::S_SHU_RD:   state_next = bra_pkg::S_SHU_WR;
      bra_pkg::S_SHU_WR:   state_next = bra_pkg::S_SHU_CHK;
      bra_pkg::S_SPLIT_LO: state_next = bra_pkg::S_SPLIT_HI;
      bra_pkg::S_SPLIT_HI: state_next = bra_pkg::S_SPLIT_CHK;
      bra_pkg::S_GRANT:    state_next = bra_pkg::S_EMIT;
      bra_pkg::S_FREE:     state_next = bra_pkg::S_MRG_CHK;
      bra_pkg::S_MRG_CHK:
        state_next = stat.has_partner ? bra_pkg::S_MRG_EV : bra_pkg::S_EMIT;
      bra_pkg::S_MRG_EV:
        state_next = stat.mrg_match ? bra_pkg::S_MRG_WR : bra_pkg::S_EMIT;
      bra_pkg::S_MRG_WR: state_next = bra_pkg::S_RM_CHK;
      bra_pkg::S_RM_CHK:
        state_next = stat.rm_done ? bra_pkg::S_RM_END : bra_pkg::S_RM_RD;
      bra_pkg::S_RM_RD:  state_next = bra_pkg::S_RM_WR;
      bra_pkg::S_RM_WR:  state_next = bra_pkg::S_RM_CHK;
      bra_pkg::S_RM_END: state_next = bra_pkg::S_MRG_CHK;
      bra_pkg::S_ERR:    state_next = bra_pkg::S_EMIT;
      bra_pkg::S_EMIT:   if (can_emit) state_next = bra_pkg::S_IDLE;
      default:           state_next = bra_pkg::S_INIT;
    endcase
  end

  always_comb begin
    op = bra_pkg::OP_NONE;
    case (state)
      bra_pkg::S_INIT:      op = bra_pkg::OP_INIT;
      bra_pkg::S_IDLE:      if (in_valid) op = bra_pkg::OP_LOAD;
      bra_pkg::S_SCAN:      op = bra_pkg::OP_SCAN;
      bra_pkg::S_SPLIT_CHK: if (stat.split_more) op = bra_pkg::OP_SHU_INIT;
      bra_pkg::S_SHU_RD:    op = bra_pkg::OP_SHU_RD;
      bra_pkg::S_SHU_WR:    op = bra_pkg::OP_SHU_WR;
      bra_pkg::S_SPLIT_LO:  op = bra_pkg::OP_SPLIT_LO;
      bra_pkg::S_SPLIT_HI:  op = bra_pkg::OP_SPLIT_HI;
      bra_pkg::S_GRANT:     op = bra_pkg::OP_GRANT;
      bra_pkg::S_FREE:      op = bra_pkg::OP_FREE;
      bra_pkg::S_MRG_CHK:   if (stat.has_partner) op = bra_pkg::OP_MRG_RD;
      bra_pkg::S_MRG_EV:    op = bra_pkg::OP_MRG_EV;
      bra_pkg::S_MRG_WR:    op = bra_pkg::OP_MRG_WR;
      bra_pkg::S_RM_RD:     op = bra_pkg::OP_RM_RD;
      bra_pkg::S_RM_WR:     op = bra_pkg::OP_RM_WR;
      bra_pkg::S_RM_END:    op = bra_pkg::OP_RM_END;
      bra_pkg::S_ERR:       op = bra_pkg::OP_ERR;
      bra_pkg::S_EMIT:      if (can_emit) op = bra_pkg::OP_EMIT;
      default:              op = bra_pkg::OP_NONE;
    endcase
  end

endmodule

FILE: src/buddy_range_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_range_allocator_core
// Buddy allocator over 2048 pages with a 64-entry address-ordered range table.
// ----------------------------------------------------------------------------
// sequence: accept, table scan, decide, then per split a shuffle of the entries above
//   and both halves written, or per merge a partner check and an entry removal, then the response
// flow: one transaction at a time, taken again once the response is loaded;
//   the response stage stalls while rsp.valid is held and rsp.ready is low
// reset: synchronous; the init state after reset writes the whole-region entry,
//   and req.ready stays low in that state
module buddy_range_allocator_core (
  input  logic        clk,
  input  logic        rst,
  bra_req_if.sink     req,
  bra_rsp_if.source   rsp
);

  bra_pkg::dp_op_t   op;
  bra_pkg::dp_stat_t stat;

  // fsm: sequences scan, split and merge steps and both handshakes
  bra_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .op        (op)
  );

  // datapath: range table, working entry, response registers
  bra_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .op           (op),
    .stat         (stat),
    .in_mode      (req.mode),
    .in_count     (req.page_count),
    .in_offset    (req.page_offset),
    .block_offset (rsp.block_offset),
    .block_pages  (rsp.block_pages),
    .status       (rsp.status)
  );

  // table never empty and never over capacity
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    stat.count != '0 && stat.count <= bra_pkg::CNT_W'(bra_pkg::MAX_RANGES))
    else $error("range count out of bounds");

  // one transaction in flight: no new request the cycle after one is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request accepted while busy");

  // successful responses carry a size, errors carry none
  a_ok_pages: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == bra_pkg::ST_OK |-> rsp.block_pages != '0)
    else $error("ok response with zero pages");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != bra_pkg::ST_OK |->
      rsp.block_pages == '0 && rsp.block_offset == '0)
    else $error("error response with nonzero payload");

endmodule
